FILE: design/video_line_frame_timing_top_assert.svh
// Assertion helpers for the video line and frame timing block.
`ifndef VIDEO_LINE_FRAME_TIMING_TOP_ASSERT_SVH
`define VIDEO_LINE_FRAME_TIMING_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define VLFT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Trigger at one edge implies the condition at the following edge.
`define VLFT_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

FILE: design/vlft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vlft_pkg;

  // Line and frame geometry for the two standards.
  localparam logic [11:0] NTSC_TICKS = 12'd3412;
  localparam logic [8:0]  NTSC_LINES = 9'd263;
  localparam logic [11:0] PAL_TICKS  = 12'd3404;
  localparam logic [8:0]  PAL_LINES  = 9'd314;
  localparam logic [23:0] EVENT_MAX  = 24'hFFFFFF;

  // Last step index of each division on the shared unit.
  localparam logic [5:0] DIV_TICK_LAST  = 6'd22;
  localparam logic [5:0] DIV_LINE_LAST  = 6'd12;
  localparam logic [5:0] DIV_EVENT_LAST = 6'd39;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CLOCK_RATIO = 3'd0;
  localparam logic [2:0] CFG_PAL_MODE    = 3'd1;
  localparam logic [2:0] CFG_INTERLACED  = 3'd2;
  localparam logic [2:0] CFG_FIRST_LINE  = 3'd3;
  localparam logic [2:0] CFG_END_LINE    = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_TICK,
    ST_LINE,
    ST_DIV_LINE,
    ST_FRAME,
    ST_PMUL,
    ST_LOAD_EVENT,
    ST_DIV_EVENT,
    ST_DONE
  } vlft_state_t;

endpackage

`default_nettype wire

FILE: design/video_line_frame_timing_top.sv
// Each input transaction passes a multiply step, then 23 + 13 + 40 steps of the shared
// restoring divider, with setup and handoff states between, before its result is ready.
// The block takes one item at a time; the divider runs one quotient bit per cycle
// and s_axis_tready stays low until the result is handed to the output register.
// Reset (rst, synchronous, active high) restores the configuration defaults,
// clears line, tick, fraction and vblank history, and selects the top field.
`timescale 1ns / 1ps
`default_nettype none

module video_line_frame_timing_top
  import vlft_pkg::*;
#(
  parameter int DELTA_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [17:0] cfg_data,
  // Input stream: [19:0] elapsed_cycles, [23:20] zero.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,
  // Output stream: [8:0] current_line, [20:9] line_tick, [21] top_field,
  // [22] in_vblank, [23] vblank_irq, [24] vblank_end, [48:25] next_event_cycles,
  // [55:49] zero.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata
);

  localparam logic [63:0] DELTA_MASK = (64'd1 << DELTA_BITS) - 64'd1;

  vlft_state_t state, state_next;

  // Configuration registers.
  logic [17:0] clock_ratio;
  logic        pal_mode;
  logic        interlaced;
  logic [9:0]  active_first_line;
  logic [9:0]  active_end_line;

  // Timing state.
  logic [15:0] tick_fraction;
  logic [11:0] tick_in_line;
  logic [8:0]  line_number;
  logic        field_is_top;
  logic        vblank_seen;

  // Working registers.
  logic [19:0] elapsed;
  logic [39:0] dq;
  logic [17:0] rem;
  logic [17:0] dv;
  logic [5:0]  cnt;
  logic [22:0] ticks_pred;
  logic        res_vb;
  logic        res_irq;
  logic        res_vend;

  logic [11:0] tpl;
  logic [8:0]  lpf;
  logic [38:0] acc;
  logic [22:0] lt_sum;
  logic [12:0] line_sum;
  logic [18:0] trial;
  logic        trial_ge;
  logic [17:0] rem_step;
  logic        vb_new;
  logic [11:0] span_lines;
  logic [22:0] span_ticks;
  logic [39:0] event_num;
  logic [23:0] event_sat;

  // Configuration is taken only while idle with no input transaction offered.
  assign cfg_ready     = (state == ST_IDLE) && !s_axis_tvalid;
  assign s_axis_tready = (state == ST_IDLE);

  assign tpl = pal_mode ? PAL_TICKS : NTSC_TICKS;
  assign lpf = pal_mode ? PAL_LINES : NTSC_LINES;

  // Scale elapsed cycles into ticks and advance within the line.
  assign acc    = 39'(tick_fraction) + 39'(elapsed) * 39'(clock_ratio);
  assign lt_sum = 23'(acc[38:16]) + 23'(tick_in_line);
  assign line_sum = 13'(line_number) + 13'(dq[11:0]);

  // One restoring division step of the shared unit.
  assign trial    = {rem, dq[39]};
  assign trial_ge = (trial >= {1'b0, dv});
  assign rem_step = trial_ge ? 18'(trial - {1'b0, dv}) : trial[17:0];

  assign vb_new = (10'(rem[8:0]) < active_first_line) || (10'(rem[8:0]) >= active_end_line);

  // Whole lines left until the next vblank boundary.
  always_comb begin
    if (12'(line_number) >= 12'(active_end_line)) begin
      span_lines = 12'(lpf) + 12'(active_first_line) - 12'(line_number) - 12'd1;
    end else if (12'(line_number) < 12'(active_first_line)) begin
      span_lines = 12'(active_first_line) - 12'd1 - 12'(line_number);
    end else begin
      span_lines = 12'(active_end_line) - 12'd1 - 12'(line_number);
    end
  end

  assign span_ticks = span_lines[10:0] * tpl;
  assign event_num  = {1'b0, ticks_pred, 16'd0} - 40'(tick_fraction)
                    + 40'(clock_ratio) - 40'd1;
  assign event_sat  = ((clock_ratio == 18'd0) || (dq[39:24] != 16'd0)) ? EVENT_MAX
                                                                        : dq[23:0];

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (s_axis_tvalid) state_next = ST_MUL;
      ST_MUL:        state_next = ST_DIV_TICK;
      ST_DIV_TICK:   if (cnt == DIV_TICK_LAST) state_next = ST_LINE;
      ST_LINE:       state_next = ST_DIV_LINE;
      ST_DIV_LINE:   if (cnt == DIV_LINE_LAST) state_next = ST_FRAME;
      ST_FRAME:      state_next = ST_PMUL;
      ST_PMUL:       state_next = ST_LOAD_EVENT;
      ST_LOAD_EVENT: state_next = ST_DIV_EVENT;
      ST_DIV_EVENT:  if (cnt == DIV_EVENT_LAST) state_next = ST_DONE;
      ST_DONE:       if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration, timing state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ratio       <= 18'd103890;
      pal_mode          <= 1'b0;
      interlaced        <= 1'b1;
      active_first_line <= 10'd16;
      active_end_line   <= 10'd256;
      tick_fraction     <= 16'd0;
      tick_in_line      <= 12'd0;
      line_number       <= 9'd0;
      field_is_top      <= 1'b1;
      vblank_seen       <= 1'b0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CLOCK_RATIO: clock_ratio       <= cfg_data;
          CFG_PAL_MODE:    pal_mode          <= cfg_data[0];
          CFG_INTERLACED:  interlaced        <= cfg_data[0];
          CFG_FIRST_LINE:  active_first_line <= cfg_data[9:0];
          CFG_END_LINE:    active_end_line   <= cfg_data[9:0];
          default: ;
        endcase
      end
      // A finished result reloads the register in the same cycle instead.
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) elapsed <= s_axis_tdata[19:0] & DELTA_MASK[19:0];
        end
        ST_MUL: begin
          tick_fraction <= acc[15:0];
          dq  <= {lt_sum, 17'd0};
          rem <= 18'd0;
          dv  <= 18'(tpl);
          cnt <= 6'd0;
        end
        ST_DIV_TICK, ST_DIV_LINE, ST_DIV_EVENT: begin
          rem <= rem_step;
          dq  <= {dq[38:0], trial_ge};
          cnt <= cnt + 6'd1;
        end
        ST_LINE: begin
          tick_in_line <= rem[11:0];
          dq  <= {line_sum, 27'd0};
          rem <= 18'd0;
          dv  <= 18'(lpf);
          cnt <= 6'd0;
        end
        ST_FRAME: begin
          // Odd frame count flips the field in interlaced mode.
          line_number <= rem[8:0];
          if (interlaced && dq[0]) field_is_top <= ~field_is_top;
          res_vb      <= vb_new;
          res_irq     <= !vblank_seen && vb_new;
          res_vend    <= vblank_seen && !vb_new;
          vblank_seen <= vb_new;
        end
        ST_PMUL: begin
          ticks_pred <= 23'(tpl - tick_in_line) + span_ticks;
        end
        ST_LOAD_EVENT: begin
          dq  <= event_num;
          rem <= 18'd0;
          dv  <= clock_ratio;
          cnt <= 6'd0;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'd0, event_sat, res_vend, res_irq, res_vb, field_is_top,
                              tick_in_line, line_number};
          end
        end
        default: ;
      endcase
    end
  end

`include "video_line_frame_timing_top_assert.svh"

  `VLFT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy")
  `VLFT_ASSERT(a_line_range, line_number < PAL_LINES, "line number out of frame range")
  `VLFT_ASSERT(a_tick_range, tick_in_line < NTSC_TICKS, "tick position out of line range")
  `VLFT_ASSERT_NEXT(a_result_out, (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid && s_axis_tready, "no result")

endmodule

`default_nettype wire

FILE: tb/tb_video_line_frame_timing_top.sv
`timescale 1ns / 1ps

module tb_video_line_frame_timing_top;
  import vlft_pkg::*;

  localparam int MAX_QUIET = 20000;

  // One display timing report as carried on the output stream.
  typedef struct packed {
    logic [23:0] next_event;
    logic        vend;
    logic        irq;
    logic        vb;
    logic        field;
    logic [11:0] tick;
    logic [8:0]  line;
  } timing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [17:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  always #6 clk = ~clk;

  video_line_frame_timing_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Shadow copy of the timing registers and counters.
  logic [17:0] ratio_q;
  logic        pal_q, interlace_q;
  logic [9:0]  first_q, end_q;
  logic [15:0] frac_q;
  logic [11:0] tick_q;
  logic [8:0]  line_q;
  logic        top_q, seen_q;

  timing_t pending_reports[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int quiet = 0;
  bit idle_off = 1'b0;
  bit long_hold = 1'b0;

  // Directed rows: elapsed count and, when known at a glance, the result line/tick.
  typedef struct {
    logic [19:0] elapsed;
    bit          known;
    logic [8:0]  line;
    logic [11:0] tick;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    '{20'd0, 1'b1, 9'd0, 12'd0},
    '{20'd1, 1'b0, 9'd0, 12'd0},
    '{20'hFFFFF, 1'b0, 9'd0, 12'd0},
    '{20'd5, 1'b0, 9'd0, 12'd0},
    '{20'd2000, 1'b0, 9'd0, 12'd0},
    '{20'd35000, 1'b0, 9'd0, 12'd0},
    '{20'h80000, 1'b0, 9'd0, 12'd0},
    '{20'h55555, 1'b0, 9'd0, 12'd0},
    '{20'hAAAAA, 1'b0, 9'd0, 12'd0},
    '{20'd1, 1'b0, 9'd0, 12'd0}
  };

  function automatic void reset_model();
    ratio_q = 18'd103890; pal_q = 1'b0; interlace_q = 1'b1;
    first_q = 10'd16; end_q = 10'd256;
    frac_q = '0; tick_q = '0; line_q = '0; top_q = 1'b1; seen_q = 1'b0;
  endfunction

  // Advance the timing state by one elapsed count and build the expected report.
  function automatic timing_t advance_timing(logic [19:0] elapsed);
    longint unsigned acc, ticks, lt, ln, tpl, lpf, q;
    longint signed t, l, f, e, remain, scaled;
    timing_t r;
    tpl = pal_q ? PAL_TICKS : NTSC_TICKS;
    lpf = pal_q ? PAL_LINES : NTSC_LINES;
    acc = longint'(frac_q) + longint'(elapsed) * longint'(ratio_q);
    frac_q = acc[15:0];
    ticks = acc >> 16;
    lt = tick_q + ticks;
    ln = line_q + lt / tpl;
    tick_q = lt % tpl;
    if (ln >= lpf) begin
      if (interlace_q && ((ln / lpf) % 2 == 1)) top_q = ~top_q;
      ln = ln % lpf;
    end
    line_q = ln;
    r.line = line_q;
    r.tick = tick_q;
    r.field = top_q;
    r.vb = (line_q < first_q) || (line_q >= end_q);
    r.irq = !seen_q && r.vb;
    r.vend = seen_q && !r.vb;
    seen_q = r.vb;
    // Cycles until the next blanking boundary, rounded up.
    t = tpl; l = line_q; f = first_q; e = end_q;
    remain = t - tick_q;
    if (l >= e) remain += (longint'(lpf) - l) * t + (f - 1) * t;
    else if (l < f) remain += (f - 1 - l) * t;
    else remain += (e - 1 - l) * t;
    if (remain < 0) remain = 0;
    scaled = remain * 65536 - frac_q;
    if (scaled < 0) scaled = 0;
    if (ratio_q == 0) r.next_event = EVENT_MAX;
    else begin
      q = (longint'(scaled) + ratio_q - 1) / ratio_q;
      r.next_event = (q > 64'hFFFFFF) ? EVENT_MAX : q[23:0];
    end
    return r;
  endfunction

  task automatic idle_burst();
    if (!idle_off && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 13)) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [17:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CLOCK_RATIO: ratio_q = val;
      CFG_PAL_MODE:    pal_q = val[0];
      CFG_INTERLACED:  interlace_q = val[0];
      CFG_FIRST_LINE:  first_q = val[9:0];
      CFG_END_LINE:    end_q = val[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(logic [19:0] elapsed);
    timing_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, elapsed};
    do @(posedge clk); while (!s_axis_tready);
    r = advance_timing(elapsed);
    pending_reports.push_back(r);
    sent++;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Random elapsed count, mostly short steps so that lines and frames advance gradually.
  function automatic logic [19:0] rand_elapsed();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 3);
      2, 3: return $urandom_range(0, 50000);
      default: return $urandom_range(0, 4000);
    endcase
  endfunction

  // Check each result transaction against the oldest expected report.
  always @(posedge clk) begin
    timing_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[48:0];
      received++;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %h", m_axis_tdata);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want || m_axis_tdata[55:49] !== 7'd0) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch at result %0d: expected %h got %h", received, want, got);
        end
      end
    end
  end

  // Receiver with random stalls and one long hold-off.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        for (n = 0; n < 600; n++) @(posedge clk);
        long_hold = 1'b0;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transaction.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > MAX_QUIET) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int i, ph;
    timing_t r;
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at reset settings.
    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].elapsed);
      if (k == 0) begin
        r = pending_reports[pending_reports.size() - 1];
        if (r.line != directed_rows[k].line || r.tick != directed_rows[k].tick) errors++;
      end
    end
    drain();

    // Zero ratio, zero first line, PAL, no interlace, extreme blank lines.
    write_reg(CFG_CLOCK_RATIO, 18'd0);
    write_reg(CFG_FIRST_LINE, 10'd0);
    send_item(20'hFFFFF);
    drain();
    write_reg(CFG_CLOCK_RATIO, 18'h3FFFF);
    write_reg(CFG_PAL_MODE, 18'd1);
    write_reg(CFG_INTERLACED, 18'd0);
    write_reg(CFG_END_LINE, 10'd1023);
    for (i = 0; i < 6; i++) send_item(i[0] ? 20'hFFFFF : 20'd3000);
    drain();
    write_reg(CFG_PAL_MODE, 18'd0);
    write_reg(CFG_INTERLACED, 18'd1);
    write_reg(CFG_FIRST_LINE, 10'd1023);
    write_reg(CFG_END_LINE, 10'd0);
    for (i = 0; i < 6; i++) send_item(i[0] ? 20'd200000 : 20'd7);
    drain();

    // Random phases over varied settings; one long output stall in the first phase.
    for (ph = 0; ph < 8; ph++) begin
      if (ph == 7) idle_off = 1'b1;
      write_reg(CFG_CLOCK_RATIO, (ph == 1) ? 18'd32768 : (ph == 2) ? 18'h3FFFF :
                $urandom_range(32768, 262143));
      write_reg(CFG_PAL_MODE, $urandom_range(0, 1));
      write_reg(CFG_INTERLACED, $urandom_range(0, 1));
      write_reg(CFG_FIRST_LINE, (ph == 3) ? 18'd1 : $urandom_range(1, 40));
      write_reg(CFG_END_LINE, (ph == 3) ? 18'd1023 : $urandom_range(200, 320));
      if (ph == 0) long_hold = 1'b1;
      for (i = 0; i < 160; i++) begin
        send_item(rand_elapsed());
        idle_burst();
      end
      drain();
    end

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
